/* hdl/polynomial_eval_with_derivatives_unit_assert.svh */
// Assertion macros for the polynomial evaluation unit.
// The macros expect signals named clk and rst_n in the module that uses them.
`ifndef POLYNOMIAL_EVAL_WITH_DERIVATIVES_UNIT_ASSERT_SVH
`define POLYNOMIAL_EVAL_WITH_DERIVATIVES_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define PEDU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pedu: same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define PEDU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pedu: next-cycle check failed");

`endif

/* hdl/pedu_pkg.sv */
// Package for the polynomial evaluation unit: data types, limits and helpers.
// No dependencies.
`timescale 1ns / 1ps

package pedu_pkg;

    localparam int NUM_COEFF  = 6;
    localparam int NUM_CHAINS = 3;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;

    typedef logic signed [31:0] coeff_t;
    typedef logic signed [47:0] acc_t;
    typedef logic signed [63:0] prod_hi_t;
    typedef logic signed [64:0] prod_lo_t;
    typedef logic signed [65:0] sum_t;

    typedef enum logic [2:0] {
        REG_COEFF_0 = 3'd0,
        REG_COEFF_1 = 3'd1,
        REG_COEFF_2 = 3'd2,
        REG_COEFF_3 = 3'd3,
        REG_COEFF_4 = 3'd4,
        REG_COEFF_5 = 3'd5
    } reg_idx_t;

    localparam acc_t   ACC_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam acc_t   ACC_MIN = 48'sh8000_0000_0000;
    localparam coeff_t OUT_MAX = 32'sh7FFF_FFFF;
    localparam coeff_t OUT_MIN = 32'sh8000_0000;

    typedef struct packed {
        coeff_t x;
        acc_t   val;
        acc_t   slp;
        acc_t   crv;
        logic   sat;
    } cell_data_t;

    typedef struct packed {
        acc_t val;
        acc_t slp;
        acc_t crv;
    } cell_coef_t;

    // Multiplies a coefficient by a small constant factor from the derivative rule.
    function automatic acc_t scale_coeff(coeff_t c, int unsigned k);
        return acc_t'(acc_t'(c) * acc_t'(k));
    endfunction

endpackage

/* hdl/pedu_if.sv */
// Channel interfaces for the polynomial evaluation unit: points in, results out.
// Depends on pedu_pkg.
`timescale 1ns / 1ps

interface pedu_in_if;
    logic             valid;
    logic             ready;
    pedu_pkg::coeff_t point;

    modport source (output valid, output point, input ready);
    modport sink   (input valid, input point, output ready);
endinterface

interface pedu_out_if;
    logic             valid;
    logic             ready;
    pedu_pkg::coeff_t value;
    pedu_pkg::coeff_t slope;
    pedu_pkg::coeff_t curvature;
    logic             saturated;

    modport source (output valid, output value, output slope, output curvature,
                    output saturated, input ready);
    modport sink   (input valid, input value, input slope, input curvature,
                    input saturated, output ready);
endinterface

/* hdl/pedu_cfg.sv */
// Coefficient register file behind the APB-style configuration port.
// Depends on pedu_pkg.
`timescale 1ns / 1ps

module pedu_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pedu_pkg::ADDR_W-1:0]   paddr,
    input  logic [pedu_pkg::DATA_W-1:0]   pwdata,
    output logic [pedu_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output pedu_pkg::coeff_t              coeff [pedu_pkg::NUM_COEFF]
);
    import pedu_pkg::*;

    coeff_t   coeff_reg [NUM_COEFF];
    reg_idx_t reg_idx;
    logic     wr_en;

    assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COEFF; i++)
            begin
                coeff_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_COEFF_0: coeff_reg[0] <= pwdata;
                REG_COEFF_1: coeff_reg[1] <= pwdata;
                REG_COEFF_2: coeff_reg[2] <= pwdata;
                REG_COEFF_3: coeff_reg[3] <= pwdata;
                REG_COEFF_4: coeff_reg[4] <= pwdata;
                REG_COEFF_5: coeff_reg[5] <= pwdata;
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_COEFF_0: prdata = coeff_reg[0];
            REG_COEFF_1: prdata = coeff_reg[1];
            REG_COEFF_2: prdata = coeff_reg[2];
            REG_COEFF_3: prdata = coeff_reg[3];
            REG_COEFF_4: prdata = coeff_reg[4];
            REG_COEFF_5: prdata = coeff_reg[5];
            default:     prdata = '0;
        endcase
    end

    assign coeff = coeff_reg;

endmodule

/* hdl/pedu_cell.sv */
// One Horner step for the value, slope and curvature chains, in two register stages.
// Depends on pedu_pkg and the assertion macro header.
`timescale 1ns / 1ps

module pedu_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  pedu_pkg::cell_data_t   in_data,
    input  pedu_pkg::cell_coef_t   coef,
    output logic                   out_valid,
    input  logic                   out_ready,
    output pedu_pkg::cell_data_t   out_data
);
    import pedu_pkg::*;
    `include "polynomial_eval_with_derivatives_unit_assert.svh"

    acc_t              acc_in  [NUM_CHAINS];
    acc_t              coef_in [NUM_CHAINS];
    logic signed [15:0] x_hi;
    logic signed [16:0] x_lo;

    logic     a_valid_reg;
    coeff_t   a_x_reg;
    logic     a_sat_reg;
    prod_hi_t a_ph_reg  [NUM_CHAINS];
    prod_hi_t a_ph_next [NUM_CHAINS];
    prod_lo_t a_pl_reg  [NUM_CHAINS];
    prod_lo_t a_pl_next [NUM_CHAINS];

    logic     b_valid_reg;
    coeff_t   b_x_reg;
    logic     b_sat_reg;
    logic     b_sat_next;
    acc_t     b_acc_reg  [NUM_CHAINS];
    acc_t     b_acc_next [NUM_CHAINS];

    logic     adv_a;
    logic     adv_b;

    assign acc_in[0]  = in_data.val;
    assign acc_in[1]  = in_data.slp;
    assign acc_in[2]  = in_data.crv;
    assign coef_in[0] = coef.val;
    assign coef_in[1] = coef.slp;
    assign coef_in[2] = coef.crv;

    // The point is split so that each product is at most 48 by 17 bits.
    assign x_hi = in_data.x[31:16];
    assign x_lo = $signed({1'b0, in_data.x[15:0]});

    assign adv_b    = !b_valid_reg || out_ready;
    assign adv_a    = !a_valid_reg || adv_b;
    assign in_ready = adv_a;

    always_comb
    begin
        for (int i = 0; i < NUM_CHAINS; i++)
        begin
            a_ph_next[i] = acc_in[i] * x_hi;
            a_pl_next[i] = acc_in[i] * x_lo;
        end
    end

    // floor(acc * x / 2^16) equals the high product plus the floored low product.
    always_comb
    begin
        sum_t sum;
        sum        = '0;
        b_sat_next = a_sat_reg;
        for (int i = 0; i < NUM_CHAINS; i++)
        begin
            sum = sum_t'(a_ph_reg[i]) + sum_t'(a_pl_reg[i] >>> 16) + sum_t'(coef_in[i]);
            if (sum > sum_t'(ACC_MAX))
            begin
                b_acc_next[i] = ACC_MAX;
                b_sat_next    = 1'b1;
            end
            else if (sum < sum_t'(ACC_MIN))
            begin
                b_acc_next[i] = ACC_MIN;
                b_sat_next    = 1'b1;
            end
            else
            begin
                b_acc_next[i] = acc_t'(sum);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_a)
            begin
                a_valid_reg <= in_valid;
            end
            if (adv_b)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_a && in_valid)
        begin
            a_x_reg   <= in_data.x;
            a_sat_reg <= in_data.sat;
            a_ph_reg  <= a_ph_next;
            a_pl_reg  <= a_pl_next;
        end
        if (adv_b && a_valid_reg)
        begin
            b_x_reg   <= a_x_reg;
            b_sat_reg <= b_sat_next;
            b_acc_reg <= b_acc_next;
        end
    end

    assign out_valid     = b_valid_reg;
    assign out_data.x    = b_x_reg;
    assign out_data.val  = b_acc_reg[0];
    assign out_data.slp  = b_acc_reg[1];
    assign out_data.crv  = b_acc_reg[2];
    assign out_data.sat  = b_sat_reg;

    `PEDU_ASSERT_NEXT(a_takes_item, in_valid && in_ready, a_valid_reg)
    `PEDU_ASSERT_NEXT(sat_carried, a_valid_reg && a_sat_reg && adv_b, b_valid_reg && b_sat_reg)
    `PEDU_ASSERT_NEXT(b_held_on_stall, b_valid_reg && !out_ready,
                      b_valid_reg && $stable(b_x_reg) && $stable(b_sat_reg))
    `PEDU_ASSERT_IMP(ready_when_empty, !a_valid_reg, in_ready)

endmodule

/* hdl/pedu_out.sv */
// Output stage: clamps the three chains to 32 bits and holds the result item.
// Depends on pedu_pkg and pedu_if.
`timescale 1ns / 1ps

module pedu_out (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  pedu_pkg::cell_data_t in_data,
    pedu_out_if.source           results
);
    import pedu_pkg::*;

    logic   out_valid_reg;
    coeff_t value_reg;
    coeff_t value_next;
    coeff_t slope_reg;
    coeff_t slope_next;
    coeff_t curv_reg;
    coeff_t curv_next;
    logic   sat_reg;
    logic   sat_next;

    function automatic coeff_t clip(acc_t a);
        if (a > acc_t'(OUT_MAX))
        begin
            return OUT_MAX;
        end
        else if (a < acc_t'(OUT_MIN))
        begin
            return OUT_MIN;
        end
        return coeff_t'(a);
    endfunction

    function automatic logic out_of_range(acc_t a);
        return (a > acc_t'(OUT_MAX)) || (a < acc_t'(OUT_MIN));
    endfunction

    always_comb
    begin
        value_next = clip(in_data.val);
        slope_next = clip(in_data.slp);
        curv_next  = clip(in_data.crv);
        sat_next   = in_data.sat || out_of_range(in_data.val)
                     || out_of_range(in_data.slp) || out_of_range(in_data.crv);
    end

    assign in_ready = !out_valid_reg || results.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            value_reg <= value_next;
            slope_reg <= slope_next;
            curv_reg  <= curv_next;
            sat_reg   <= sat_next;
        end
    end

    assign results.valid     = out_valid_reg;
    assign results.value     = value_reg;
    assign results.slope     = slope_reg;
    assign results.curvature = curv_reg;
    assign results.saturated = sat_reg;

endmodule

/* hdl/polynomial_eval_with_derivatives_unit.sv */
// Channel     Direction  Payload
// samples     in         point (signed Q16.16)
// results     out        value, slope, curvature (signed Q16.16), saturated
// cfg (APB)   in/out     coeff_0 .. coeff_5 at byte addresses 0, 4, .. 20
//
// One item is taken per cycle unless a stall on results backs up to the input;
// each passes DEGREE Horner cells of two stages each and then the output
// register. A stall on results backs up cell by cell; empty stages keep
// taking items. Reset empties the pipeline and clears the coefficients.
// Depends on pedu_pkg, pedu_if, pedu_cfg, pedu_cell and pedu_out.
`timescale 1ns / 1ps

module polynomial_eval_with_derivatives_unit #(
    parameter int DEGREE = 5
) (
    input  logic                          clk,
    input  logic                          rst_n,
    pedu_in_if.sink                       samples,
    pedu_out_if.source                    results,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pedu_pkg::ADDR_W-1:0]   paddr,
    input  logic [pedu_pkg::DATA_W-1:0]   pwdata,
    output logic [pedu_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import pedu_pkg::*;

    coeff_t     coeff       [NUM_COEFF];
    cell_data_t stage_data  [DEGREE+1];
    logic       stage_valid [DEGREE+1];
    logic       stage_ready [DEGREE+1];

    pedu_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coeff   (coeff)
    );

    // Derivatives start at zero; step 1 adds the top slope term, step 2 the top curvature.
    always_comb
    begin
        stage_data[0].x   = samples.point;
        stage_data[0].val = acc_t'(coeff[DEGREE]);
        stage_data[0].slp = '0;
        stage_data[0].crv = '0;
        stage_data[0].sat = 1'b0;
    end

    assign stage_valid[0] = samples.valid;
    assign samples.ready  = stage_ready[0];

    for (genvar j = 0; j < DEGREE; j++)
    begin : g_cell
        localparam int M = DEGREE - 1 - j;
        cell_coef_t cc;

        assign cc.val = acc_t'(coeff[M]);
        assign cc.slp = scale_coeff(coeff[M+1], M + 1);
        if (M + 2 <= DEGREE)
        begin : g_crv
            assign cc.crv = scale_coeff(coeff[M+2], (M + 2) * (M + 1));
        end
        else
        begin : g_crv_zero
            assign cc.crv = '0;
        end

        pedu_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[j]),
            .in_ready  (stage_ready[j]),
            .in_data   (stage_data[j]),
            .coef      (cc),
            .out_valid (stage_valid[j+1]),
            .out_ready (stage_ready[j+1]),
            .out_data  (stage_data[j+1])
        );
    end

    pedu_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (stage_valid[DEGREE]),
        .in_ready (stage_ready[DEGREE]),
        .in_data  (stage_data[DEGREE]),
        .results  (results)
    );

endmodule

/* test/pedu_eval_checker.sv */
// Checker for the polynomial evaluation unit: follows coefficient writes on the
// APB port, predicts value, slope and curvature for each point and compares them.
// Depends on pedu_pkg and pedu_if.
`timescale 1ns / 1ps

module pedu_eval_checker #(
    parameter int DEGREE = 5
) (
    input  logic                        clk,
    input  logic                        rst_n,
    pedu_in_if                          samples,
    pedu_out_if                         results,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [pedu_pkg::ADDR_W-1:0] paddr,
    input  logic [pedu_pkg::DATA_W-1:0] pwdata,
    output int                          mismatches,
    output int                          evals_due
);
    import pedu_pkg::*;

    typedef struct packed {
        coeff_t value;
        coeff_t slope;
        coeff_t curvature;
        logic   saturated;
    } poly_eval_t;

    typedef acc_t [NUM_COEFF-1:0] term_row_t;

    coeff_t     coeff_regs [NUM_COEFF];
    poly_eval_t evals_queue [$];
    int         fault_tally;

    function automatic coeff_t horner_sat(term_row_t terms, int n, coeff_t x,
                                          inout logic clipped);
        logic signed [95:0] acc;
        if (n <= 0)
        begin
            return '0;
        end
        acc = $signed(terms[n - 1]);
        for (int k = n - 2; k >= 0; k--)
        begin
            // The product is exact; the arithmetic shift rounds toward minus infinity.
            acc = ((acc * $signed(x)) >>> 16) + $signed(terms[k]);
            if (acc > ACC_MAX)
            begin
                acc = ACC_MAX;
                clipped = 1'b1;
            end
            else if (acc < ACC_MIN)
            begin
                acc = ACC_MIN;
                clipped = 1'b1;
            end
        end
        if (acc > OUT_MAX)
        begin
            acc = OUT_MAX;
            clipped = 1'b1;
        end
        else if (acc < OUT_MIN)
        begin
            acc = OUT_MIN;
            clipped = 1'b1;
        end
        return coeff_t'(acc[31:0]);
    endfunction

    function automatic poly_eval_t predict_eval(coeff_t x);
        term_row_t  base_terms;
        term_row_t  slope_terms;
        term_row_t  curve_terms;
        poly_eval_t r;
        logic       clipped;
        base_terms  = '0;
        slope_terms = '0;
        curve_terms = '0;
        clipped     = 1'b0;
        for (int k = 0; k <= DEGREE && k < NUM_COEFF; k++)
        begin
            base_terms[k] = acc_t'(coeff_regs[k]);
        end
        for (int k = 0; k + 1 <= DEGREE && k + 1 < NUM_COEFF; k++)
        begin
            slope_terms[k] = acc_t'(coeff_regs[k + 1]) * acc_t'(k + 1);
        end
        for (int k = 0; k + 2 <= DEGREE && k + 2 < NUM_COEFF; k++)
        begin
            curve_terms[k] = acc_t'(coeff_regs[k + 2]) * acc_t'((k + 2) * (k + 1));
        end
        r.value     = horner_sat(base_terms, DEGREE + 1, x, clipped);
        r.slope     = horner_sat(slope_terms, DEGREE, x, clipped);
        r.curvature = horner_sat(curve_terms, DEGREE - 1, x, clipped);
        r.saturated = clipped;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        poly_eval_t due;
        if (!rst_n)
        begin
            foreach (coeff_regs[i])
            begin
                coeff_regs[i] = '0;
            end
            evals_queue.delete();
            fault_tally = 0;
            mismatches <= 0;
            evals_due  <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr[ADDR_W-1:2] < NUM_COEFF)
            begin
                coeff_regs[paddr[ADDR_W-1:2]] = coeff_t'(pwdata);
            end
            if (samples.valid && samples.ready)
            begin
                evals_queue.push_back(predict_eval(samples.point));
            end
            if (results.valid && results.ready)
            begin
                if (evals_queue.size() == 0)
                begin
                    $error("result item with no point outstanding: value %0d",
                           $signed(results.value));
                    fault_tally++;
                end
                else
                begin
                    due = evals_queue.pop_front();
                    if (results.value !== due.value)
                    begin
                        $error("value: expected %0d, got %0d",
                               $signed(due.value), $signed(results.value));
                        fault_tally++;
                    end
                    if (results.slope !== due.slope)
                    begin
                        $error("slope: expected %0d, got %0d",
                               $signed(due.slope), $signed(results.slope));
                        fault_tally++;
                    end
                    if (results.curvature !== due.curvature)
                    begin
                        $error("curvature: expected %0d, got %0d",
                               $signed(due.curvature), $signed(results.curvature));
                        fault_tally++;
                    end
                    if (results.saturated !== due.saturated)
                    begin
                        $error("saturated: expected %0b, got %0b",
                               due.saturated, results.saturated);
                        fault_tally++;
                    end
                end
            end
            mismatches <= fault_tally;
            evals_due  <= evals_queue.size();
        end
    end

endmodule

/* test/polynomial_eval_with_derivatives_unit_test.sv */
// Top of the polynomial evaluation unit testbench: clock, reset, coefficient
// writes over APB, point stimulus with random gaps and back-pressure, verdict.
// Depends on pedu_pkg, pedu_if, the unit itself and pedu_eval_checker.
`timescale 1ns / 1ps

module polynomial_eval_with_derivatives_unit_test;
    import pedu_pkg::*;

    localparam int POLY_DEGREE    = 5;
    localparam int DRAIN_CYCLES   = 2 * POLY_DEGREE + 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_ITEMS    = 80;

    typedef enum int {
        PLAN_SMALL,
        PLAN_LOW_DEGREE,
        PLAN_FULL,
        PLAN_EXTREME,
        PLAN_WIDE,
        PLAN_OFFSET
    } coeff_plan_kind_t;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              psel         = 1'b0;
    logic              penable      = 1'b0;
    logic              pwrite       = 1'b0;
    logic [ADDR_W-1:0] paddr        = '0;
    logic [DATA_W-1:0] pwdata       = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              offer_valid  = 1'b0;
    coeff_t            offer_pt     = '0;
    logic              take_ready   = 1'b0;
    int                send_idle_pct = 30;
    int                recv_idle_pct = 68;
    int                stalled_cycles = 0;
    int                mismatches;
    int                evals_due;
    coeff_t            coeff_plan [NUM_COEFF];

    pedu_in_if  samples_ch ();
    pedu_out_if results_ch ();

    assign samples_ch.valid = offer_valid;
    assign samples_ch.point = offer_pt;
    assign results_ch.ready = take_ready;

    polynomial_eval_with_derivatives_unit #(
        .DEGREE (POLY_DEGREE)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_ch),
        .results (results_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    pedu_eval_checker #(
        .DEGREE (POLY_DEGREE)
    ) eval_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .samples    (samples_ch),
        .results    (results_ch),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .mismatches (mismatches),
        .evals_due  (evals_due)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        take_ready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((offer_valid && samples_ch.ready) || (results_ch.valid && take_ready) || psel)
        begin
            stalled_cycles <= 0;
        end
        else
        begin
            stalled_cycles <= stalled_cycles + 1;
        end
        if (stalled_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic coeff_t rand_fixed(int unsigned span);
        return coeff_t'($urandom_range(0, 2 * span)) - coeff_t'(span);
    endfunction

    function automatic coeff_t rand_point();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            return rand_fixed(1 << 17);
        end
        if (pick < 80)
        begin
            return rand_fixed(1 << 20);
        end
        return coeff_t'($urandom());
    endfunction

    task automatic offer_point(coeff_t x);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            offer_valid <= 1'b0;
            @(posedge clk);
        end
        offer_valid <= 1'b1;
        offer_pt    <= x;
        do @(posedge clk); while (!samples_ch.ready);
    endtask

    task automatic settle_pipeline();
        offer_valid <= 1'b0;
        do @(posedge clk); while (evals_due != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_coeff(reg_idx_t idx, coeff_t v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
    endtask

    // Coefficients change only once every point in flight has produced its item.
    task automatic apply_coeff_plan();
        settle_pipeline();
        for (int i = 0; i < NUM_COEFF; i++)
        begin
            write_coeff(reg_idx_t'(i), coeff_plan[i]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic plan_random(coeff_plan_kind_t kind);
        for (int i = 0; i < NUM_COEFF; i++)
        begin
            case (kind)
                PLAN_SMALL:      coeff_plan[i] = rand_fixed(1 << 18);
                PLAN_LOW_DEGREE: coeff_plan[i] = (i < 3) ? rand_fixed(1 << 18) : '0;
                PLAN_FULL:       coeff_plan[i] = coeff_t'($urandom());
                PLAN_EXTREME:    coeff_plan[i] = $urandom_range(0, 1) ? OUT_MAX : OUT_MIN;
                PLAN_WIDE:       coeff_plan[i] = rand_fixed(1 << 24);
                default:         coeff_plan[i] = (i == 0) ? coeff_t'($urandom())
                                                          : rand_fixed(1 << 14);
            endcase
        end
    endtask

    initial
    begin
        coeff_t probes [$];

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Coefficients still at their reset value of zero.
        probes = {32'sh0000_0000, 32'sh7FFF_FFFF};
        foreach (probes[i]) offer_point(probes[i]);

        coeff_plan = '{32'sh0001_8000, -32'sh0002_0000, 32'sh0000_4000,
                       32'sh0001_0000, -32'sh0000_8000, 32'sh0000_2000};
        apply_coeff_plan();
        probes = {32'sh0000_0000, 32'sh0000_0001, -32'sh0000_0001, 32'sh0001_0000,
                  -32'sh0001_0000, 32'sh0000_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
                  32'sh0002_8000, -32'sh0003_1234};
        foreach (probes[i]) offer_point(probes[i]);

        // Extreme coefficients drive the intermediate and output clamps.
        coeff_plan = '{default: OUT_MAX};
        apply_coeff_plan();
        probes = {32'sh0001_0000, -32'sh0001_0000, 32'sh7FFF_FFFF, 32'sh8000_0000};
        foreach (probes[i]) offer_point(probes[i]);

        coeff_plan = '{default: OUT_MIN};
        apply_coeff_plan();
        probes = {32'sh0000_0001, 32'sh0001_0000, 32'sh7FFF_FFFF, 32'sh8000_0000};
        foreach (probes[i]) offer_point(probes[i]);

        // A quadratic: the upper coefficients are zero.
        coeff_plan = '{-32'sh0005_0000, 32'sh0001_2345, 32'sh0003_0000,
                       32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000};
        apply_coeff_plan();
        probes = {32'sh0002_0000, -32'sh0000_8000};
        foreach (probes[i]) offer_point(probes[i]);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase < 4)
            begin
                send_idle_pct = 30;
                recv_idle_pct = 68;
            end
            else if (phase < 8)
            begin
                send_idle_pct = 68;
                recv_idle_pct = 30;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            plan_random(coeff_plan_kind_t'(phase % 6));
            apply_coeff_plan();
            repeat (PHASE_ITEMS) offer_point(rand_point());
        end

        settle_pipeline();
        if (mismatches == 0 && evals_due == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/pedu_pkg.sv
hdl/pedu_if.sv
hdl/pedu_cfg.sv
hdl/pedu_cell.sv
hdl/pedu_out.sv
hdl/polynomial_eval_with_derivatives_unit.sv
test/pedu_eval_checker.sv
test/polynomial_eval_with_derivatives_unit_test.sv
